### rtl/rti_pkg.sv
`default_nettype none
package rti_pkg;

  typedef logic signed [19:0] crd_t;
  typedef logic signed [20:0] s21_t;
  typedef logic signed [42:0] s43_t;
  typedef logic signed [65:0] s66_t;

  // Epsilon 0.001 at the 2^30 scale of the determinant.
  localparam s66_t EPS     = 66'sd1073742;
  localparam s66_t EPS_NEG = -66'sd1073742;

  // Unit length in Q1.14.
  localparam logic [14:0] NRM_ONE = 15'd16384;

  localparam int QDEPTH    = 4;
  localparam int QB        = $clog2(QDEPTH);
  localparam int DIV_STEPS = 32;

  localparam logic [2:0] REG_VERTEX_A  = 3'd0;
  localparam logic [2:0] REG_VERTEX_B  = 3'd1;
  localparam logic [2:0] REG_VERTEX_C  = 3'd2;
  localparam logic [2:0] REG_ONE_SIDED = 3'd3;
  localparam logic [2:0] REG_MIN_DIST  = 3'd4;
  localparam logic [2:0] REG_MATERIAL  = 3'd5;

  typedef struct packed {
    crd_t origin_x;
    crd_t origin_y;
    crd_t origin_z;
    crd_t dir_x;
    crd_t dir_y;
    crd_t dir_z;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_distance;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [7:0]         hit_material;
  } res_t;

  typedef struct packed {
    logic [59:0]        vertex_a;
    logic [59:0]        vertex_b;
    logic [59:0]        vertex_c;
    logic               one_sided;
    logic signed [31:0] near_limit;
    logic [7:0]         material_tag;
  } cfg_t;

  typedef struct packed {
    logic [14:0] mag_x;
    logic [14:0] mag_y;
    logic [14:0] mag_z;
    logic        neg_x;
    logic        neg_y;
    logic        neg_z;
    logic        busy;
  } nrm_t;

  // Classified ray handed from the front end to the divider.
  typedef struct packed {
    logic        miss;
    logic        flip;
    logic        xneg;
    logic [62:0] xmag;
    logic [62:0] dmag;
  } cls_t;

  function automatic crd_t coord(input logic [59:0] v, input int k);
    return v[k*20 +: 20];
  endfunction

  function automatic s43_t cross_term(input s21_t a, input s21_t b,
                                      input s21_t c, input s21_t d);
    s43_t ax, bx, cx, dx;
    ax = a;
    bx = b;
    cx = c;
    dx = d;
    return ax * bx - cx * dx;
  endfunction

  function automatic s66_t dot3(input s43_t p0, input s43_t p1, input s43_t p2,
                                input s21_t e0, input s21_t e1, input s21_t e2);
    s66_t a0, a1, a2, b0, b1, b2;
    a0 = p0;
    a1 = p1;
    a2 = p2;
    b0 = e0;
    b1 = e1;
    b2 = e2;
    return a0 * b0 + a1 * b1 + a2 * b2;
  endfunction

endpackage
`default_nettype wire

### rtl/rti_if.sv
`default_nettype none
interface rti_ray_if;
  import rti_pkg::*;
  logic valid;
  logic ready;
  ray_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface rti_res_if;
  import rti_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/rti_normal.sv
`default_nettype none
module rti_normal (
  input  logic          clk,
  input  logic          rst,
  input  rti_pkg::cfg_t cfg,
  input  logic          start,
  output rti_pkg::nrm_t nrm
);
  import rti_pkg::*;

  typedef enum logic [2:0] {
    N_IDLE, N_CROSS, N_SCALE, N_SQ, N_ROOT, N_DLOAD, N_DIV
  } nstate_t;

  nstate_t     state;
  logic [42:0] a [3];
  logic        sgn [3];
  logic [14:0] mag [3];
  logic [63:0] sum, rn, res;
  logic [4:0]  k, j;
  logic [1:0]  idx;
  logic [32:0] rem;
  logic [16:0] qv, low;

  s21_t        e1 [3];
  s21_t        e2 [3];
  s43_t        n [3];
  logic [42:0] mx;
  logic [29:0] asel;
  logic [59:0] sqv;
  logic [63:0] rbit, rtry;
  logic [44:0] num;
  logic [32:0] rem2, l33;
  logic        ge;
  logic [16:0] qnext;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = s21_t'(coord(cfg.vertex_b, i)) - s21_t'(coord(cfg.vertex_a, i));
      e2[i] = s21_t'(coord(cfg.vertex_c, i)) - s21_t'(coord(cfg.vertex_a, i));
    end
    n[0] = cross_term(e1[1], e2[2], e1[2], e2[1]);
    n[1] = cross_term(e1[2], e2[0], e1[0], e2[2]);
    n[2] = cross_term(e1[0], e2[1], e1[1], e2[0]);
    mx = a[0];
    if (a[1] > mx) mx = a[1];
    if (a[2] > mx) mx = a[2];
    asel  = a[idx][29:0];
    sqv   = {30'b0, asel} * {30'b0, asel};
    rbit  = 64'd1 << {k, 1'b0};
    rtry  = res + rbit;
    num   = {1'b0, asel, 14'b0} + {14'b0, res[31:1]};
    rem2  = {rem[31:0], low[16]};
    l33   = {1'b0, res[31:0]};
    ge    = rem2 >= l33;
    qnext = {qv[15:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      for (int i = 0; i < 3; i++) begin
        mag[i] <= '0;
        sgn[i] <= 1'b0;
      end
    end else if (start) begin
      state <= N_CROSS;
    end else begin
      unique case (state)
        N_IDLE: ;
        N_CROSS: begin
          for (int i = 0; i < 3; i++) begin
            a[i]   <= n[i][42] ? unsigned'(-n[i]) : unsigned'(n[i]);
            sgn[i] <= n[i][42];
          end
          state <= N_SCALE;
        end
        N_SCALE: begin
          // Bring the largest magnitude into [2^29, 2^30) one bit a cycle.
          if (mx == '0) begin
            for (int i = 0; i < 3; i++) mag[i] <= '0;
            state <= N_IDLE;
          end else if (mx[42:30] != '0) begin
            for (int i = 0; i < 3; i++) a[i] <= a[i] >> 1;
          end else if (!mx[29]) begin
            for (int i = 0; i < 3; i++) a[i] <= a[i] << 1;
          end else begin
            sum   <= '0;
            idx   <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          sum <= sum + {4'b0, sqv};
          if (idx == 2'd2) begin
            rn    <= sum + {4'b0, sqv};
            res   <= '0;
            k     <= 5'd31;
            state <= N_ROOT;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        N_ROOT: begin
          if (rn >= rtry) begin
            rn  <= rn - rtry;
            res <= (res >> 1) + rbit;
          end else begin
            res <= res >> 1;
          end
          if (k == '0) begin
            idx   <= '0;
            state <= N_DLOAD;
          end else begin
            k <= k - 5'd1;
          end
        end
        N_DLOAD: begin
          rem   <= {5'b0, num[44:17]};
          low   <= num[16:0];
          qv    <= '0;
          j     <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          rem <= ge ? rem2 - l33 : rem2;
          qv  <= qnext;
          low <= low << 1;
          if (j == 5'd16) begin
            mag[idx] <= (qnext > {2'b0, NRM_ONE}) ? NRM_ONE : qnext[14:0];
            if (idx == 2'd2) begin
              state <= N_IDLE;
            end else begin
              idx   <= idx + 2'd1;
              state <= N_DLOAD;
            end
          end else begin
            j <= j + 5'd1;
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  assign nrm.mag_x = mag[0];
  assign nrm.mag_y = mag[1];
  assign nrm.mag_z = mag[2];
  assign nrm.neg_x = sgn[0];
  assign nrm.neg_y = sgn[1];
  assign nrm.neg_z = sgn[2];
  assign nrm.busy  = state != N_IDLE;

endmodule
`default_nettype wire

### rtl/rti_front.sv
`default_nettype none
module rti_front (
  input  logic          clk,
  input  logic          rst,
  input  rti_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  rti_pkg::ray_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rti_pkg::cls_t out_data
);
  import rti_pkg::*;

  logic [3:0] v;
  logic       en;

  s21_t e1 [3];
  s21_t e2 [3];
  s21_t o_in [3];
  s21_t d_in [3];

  s21_t t1 [3];
  s21_t d1 [3];
  s43_t p2 [3];
  s43_t q2 [3];
  s21_t t2 [3];
  s21_t d2 [3];
  s66_t det3, un3, vn3, xn3;
  cls_t c4, cls;

  assign en        = !v[3] || out_ready;
  assign in_ready  = en;
  assign out_valid = v[3];
  assign out_data  = c4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = s21_t'(coord(cfg.vertex_b, i)) - s21_t'(coord(cfg.vertex_a, i));
      e2[i] = s21_t'(coord(cfg.vertex_c, i)) - s21_t'(coord(cfg.vertex_a, i));
    end
    o_in[0] = s21_t'(in_data.origin_x);
    o_in[1] = s21_t'(in_data.origin_y);
    o_in[2] = s21_t'(in_data.origin_z);
    d_in[0] = s21_t'(in_data.dir_x);
    d_in[1] = s21_t'(in_data.dir_y);
    d_in[2] = s21_t'(in_data.dir_z);
  end

  // Classification of the dot products, after the last multiply stage.
  always_comb begin
    logic neg, rej;
    s66_t detp, unp, vnp, xnp, xabs;
    if (cfg.one_sided) rej = det3 < EPS;
    else rej = (det3 > EPS_NEG) && (det3 < EPS);
    neg  = det3[65];
    detp = neg ? -det3 : det3;
    unp  = neg ? -un3 : un3;
    vnp  = neg ? -vn3 : vn3;
    xnp  = neg ? -xn3 : xn3;
    if (unp < 0 || unp > detp) rej = 1'b1;
    if (vnp < 0 || vnp > detp - unp) rej = 1'b1;
    xabs      = xnp[65] ? -xnp : xnp;
    cls.miss  = rej;
    cls.flip  = neg;
    cls.xneg  = xnp[65];
    cls.xmag  = xabs[62:0];
    cls.dmag  = detp[62:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], in_valid};
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t1[i] <= o_in[i] - s21_t'(coord(cfg.vertex_a, i));
        d1[i] <= d_in[i];
        t2[i] <= t1[i];
        d2[i] <= d1[i];
      end
      p2[0] <= cross_term(d1[1], e2[2], d1[2], e2[1]);
      p2[1] <= cross_term(d1[2], e2[0], d1[0], e2[2]);
      p2[2] <= cross_term(d1[0], e2[1], d1[1], e2[0]);
      q2[0] <= cross_term(t1[1], e1[2], t1[2], e1[1]);
      q2[1] <= cross_term(t1[2], e1[0], t1[0], e1[2]);
      q2[2] <= cross_term(t1[0], e1[1], t1[1], e1[0]);
      det3  <= dot3(p2[0], p2[1], p2[2], e1[0], e1[1], e1[2]);
      un3   <= dot3(p2[0], p2[1], p2[2], t2[0], t2[1], t2[2]);
      vn3   <= dot3(q2[0], q2[1], q2[2], d2[0], d2[1], d2[2]);
      xn3   <= dot3(q2[0], q2[1], q2[2], e2[0], e2[1], e2[2]);
      c4    <= cls;
    end
  end

endmodule
`default_nettype wire

### rtl/rti_queue.sv
`default_nettype none
module rti_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rti_pkg::cls_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rti_pkg::cls_t out_data
);
  import rti_pkg::*;

  cls_t        mem [QDEPTH];
  logic [QB-1:0] wp, rp;
  logic [QB:0]   cnt;
  logic          push, pop;

  assign in_ready  = cnt != (QB+1)'(QDEPTH);
  assign out_valid = cnt != '0;
  assign out_data  = mem[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (QB+1)'(push) - (QB+1)'(pop);
    end
    if (push) mem[wp] <= in_data;
  end

endmodule
`default_nettype wire

### rtl/rti_back.sv
`default_nettype none
module rti_back (
  input  logic          clk,
  input  logic          rst,
  input  rti_pkg::cfg_t cfg,
  input  rti_pkg::nrm_t nrm,
  input  logic          in_valid,
  output logic          in_ready,
  input  rti_pkg::cls_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rti_pkg::res_t out_data
);
  import rti_pkg::*;

  typedef struct packed {
    logic        v;
    logic        miss;
    logic        flip;
    logic        xneg;
    logic        ovf;
    logic [62:0] dmag;
    logic [63:0] rem;
    logic [31:0] q;
    logic [15:0] low;
  } dst_t;

  localparam logic signed [33:0] MAX34 = 34'sd2147483647;

  dst_t st [DIV_STEPS+1];
  dst_t st0;
  logic en;
  logic out_v;
  res_t out_r, res_c;

  // One quotient bit of floor(|xn| * 2^16 / det) per stage.
  function automatic dst_t div_step(input dst_t s);
    dst_t        r;
    logic [63:0] rem2;
    r    = s;
    rem2 = {s.rem[62:0], s.low[15]};
    r.low = s.low << 1;
    if (rem2 >= {1'b0, s.dmag}) begin
      r.rem = rem2 - {1'b0, s.dmag};
      r.q   = {s.q[30:0], 1'b1};
    end else begin
      r.rem = rem2;
      r.q   = {s.q[30:0], 1'b0};
    end
    return r;
  endfunction

  assign en        = !out_v || out_ready;
  assign in_ready  = en;
  assign out_valid = out_v;
  assign out_data  = out_r;

  always_comb begin
    st0.v    = in_valid;
    st0.miss = in_data.miss;
    st0.flip = in_data.flip;
    st0.xneg = in_data.xneg;
    // A quotient of 2^32 or more cannot be represented in Q16.16.
    st0.ovf  = {16'b0, in_data.xmag} >= {in_data.dmag, 16'b0};
    st0.dmag = in_data.dmag;
    st0.rem  = {17'b0, in_data.xmag[62:16]};
    st0.q    = '0;
    st0.low  = in_data.xmag[15:0];
  end

  always_comb begin
    dst_t               f;
    logic signed [33:0] qx, tq, md;
    logic               hit;
    logic [15:0]        mx, my, mz;
    f    = st[DIV_STEPS];
    qx   = signed'({2'b0, f.q});
    tq   = f.xneg ? -(qx + 34'(f.rem != '0)) : qx;
    md   = 34'(cfg.near_limit);
    hit  = !f.miss && (f.ovf ? !f.xneg : (tq >= md));
    mx   = {1'b0, nrm.mag_x};
    my   = {1'b0, nrm.mag_y};
    mz   = {1'b0, nrm.mag_z};
    res_c = '0;
    if (hit) begin
      res_c.hit          = 1'b1;
      res_c.hit_distance = (f.ovf || tq > MAX34) ? MAX34[31:0] : tq[31:0];
      res_c.normal_x     = (nrm.neg_x ^ f.flip) ? -mx : mx;
      res_c.normal_y     = (nrm.neg_y ^ f.flip) ? -my : my;
      res_c.normal_z     = (nrm.neg_z ^ f.flip) ? -mz : mz;
      res_c.hit_material = cfg.material_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) st[k].v <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      st[0] <= st0;
      for (int k = 0; k < DIV_STEPS; k++) st[k+1] <= div_step(st[k]);
      out_v <= st[DIV_STEPS].v;
      out_r <= res_c;
    end
  end

endmodule
`default_nettype wire

### rtl/ray_triangle_intersect_core.sv
// Ray against triangle intersection core.
// Rays arrive on the "ray" channel (origin and direction, Q10.10) and one
// result per ray leaves on the "res" channel: hit flag, distance (Q16.16,
// saturated), unit face normal (Q1.14) and material tag; a miss is all zero.
// The triangle, culling mode, minimum distance and tag sit in registers on
// the APB port, one 64-bit register every 8 bytes.
// A new ray is taken every cycle unless the normal is being recomputed or the
// receiver stalls. A result leaves after its ray passes four multiply and
// classify stages, the four-entry queue, and a 32-stage divider pipeline that
// forms one distance bit per stage, plus the output register.
// The face normal depends only on the vertices and is computed by a
// sequential unit after each vertex write (scaling, sum of squares, a
// 32-step square root, three 17-step divisions); the ray channel holds
// ready low until it is done.
// When the receiver stalls, the divider pipeline holds, the queue fills and
// then the front stages hold; ray ready falls once the queue is full and the
// last front stage holds a ray.
// Reset clears the configuration registers and the normal and empties the
// pipelines.
`default_nettype none
module ray_triangle_intersect_core (
  input  logic        clk,
  input  logic        rst,
  rti_ray_if.sink     ray,
  rti_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import rti_pkg::*;

  cfg_t       cfg;
  nrm_t       nrm;
  logic [2:0] ridx;
  logic       wr;
  logic       front_ready;
  logic       fq_valid, fq_ready, qb_valid, qb_ready;
  cls_t       fq_data, qb_data;

  assign pready = 1'b1;
  assign ridx   = paddr[5:3];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (ridx)
        REG_VERTEX_A:  cfg.vertex_a     <= pwdata[59:0];
        REG_VERTEX_B:  cfg.vertex_b     <= pwdata[59:0];
        REG_VERTEX_C:  cfg.vertex_c     <= pwdata[59:0];
        REG_ONE_SIDED: cfg.one_sided    <= pwdata[0];
        REG_MIN_DIST:  cfg.near_limit   <= pwdata[31:0];
        REG_MATERIAL:  cfg.material_tag <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_VERTEX_A:  prdata = {4'b0, cfg.vertex_a};
      REG_VERTEX_B:  prdata = {4'b0, cfg.vertex_b};
      REG_VERTEX_C:  prdata = {4'b0, cfg.vertex_c};
      REG_ONE_SIDED: prdata = {63'b0, cfg.one_sided};
      REG_MIN_DIST:  prdata = {32'b0, cfg.near_limit};
      REG_MATERIAL:  prdata = {56'b0, cfg.material_tag};
      default:       prdata = '0;
    endcase
  end

  rti_normal u_normal (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .start (wr && (ridx == REG_VERTEX_A || ridx == REG_VERTEX_B ||
                   ridx == REG_VERTEX_C)),
    .nrm   (nrm)
  );

  assign ray.ready = front_ready && !nrm.busy;

  rti_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (ray.valid && !nrm.busy),
    .in_ready  (front_ready),
    .in_data   (ray.data),
    .out_valid (fq_valid),
    .out_ready (fq_ready),
    .out_data  (fq_data)
  );

  rti_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  rti_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .nrm       (nrm),
    .in_valid  (qb_valid),
    .in_ready  (qb_ready),
    .in_data   (qb_data),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (res.data)
  );

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.data.hit |->
      res.data.hit_distance == 0 && res.data.normal_x == 0 &&
      res.data.normal_y == 0 && res.data.normal_z == 0 &&
      res.data.hit_material == 0)
    else $error("miss result carries nonzero fields");

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    nrm.busy |-> !ray.ready)
    else $error("ray taken while the normal is being recomputed");

  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    !nrm.busy |-> nrm.mag_x <= NRM_ONE && nrm.mag_y <= NRM_ONE &&
                  nrm.mag_z <= NRM_ONE)
    else $error("normal component exceeds unit length");

endmodule
`default_nettype wire

### test/tb_top.sv
module tb_top;
  import rti_pkg::*;

  localparam logic [5:0] ADDR_VA = 6'(REG_VERTEX_A * 8);
  localparam logic [5:0] ADDR_VB = 6'(REG_VERTEX_B * 8);
  localparam logic [5:0] ADDR_VC = 6'(REG_VERTEX_C * 8);
  localparam logic [5:0] ADDR_OS = 6'(REG_ONE_SIDED * 8);
  localparam logic [5:0] ADDR_MD = 6'(REG_MIN_DIST * 8);
  localparam logic [5:0] ADDR_MT = 6'(REG_MATERIAL * 8);
  localparam longint EPS_DET = 1073742;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  rti_ray_if ray_ch ();
  rti_res_if res_ch ();

  ray_triangle_intersect_core dut (
    .clk(clk), .rst(rst), .ray(ray_ch.sink), .res(res_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Testbench copy of the triangle registers.
  cfg_t tri_cfg;

  ray_t pending_rays[$];
  res_t expected_res[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  bit ray_valid_r = 1'b0;
  bit res_ready_r = 1'b0;
  ray_t ray_data_r = '0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("status: fail");
    $finish;
  end

  assign ray_ch.valid = ray_valid_r;
  assign ray_ch.data = ray_data_r;
  assign res_ch.ready = res_ready_r;

  function automatic longint sx20(logic [19:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint iabs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint isqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // Intersection test in wide exact integers.
  function automatic res_t intersect_ray(ray_t r);
    res_t o;
    longint a[3], b[3], c[3], org[3], d[3], e1[3], e2[3], tv[3], p[3], q[3];
    longint nv[3], m[3], mx, s, l, cq, md;
    logic signed [127:0] det, un, vn, xn, tq, num, q128;
    bit neg;
    o = '0;
    for (int i = 0; i < 3; i++) begin
      a[i] = sx20(tri_cfg.vertex_a[i*20 +: 20]);
      b[i] = sx20(tri_cfg.vertex_b[i*20 +: 20]);
      c[i] = sx20(tri_cfg.vertex_c[i*20 +: 20]);
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
    end
    org[0] = sx20(r.origin_x); org[1] = sx20(r.origin_y); org[2] = sx20(r.origin_z);
    d[0] = sx20(r.dir_x); d[1] = sx20(r.dir_y); d[2] = sx20(r.dir_z);
    for (int i = 0; i < 3; i++) tv[i] = org[i] - a[i];
    p[0] = d[1]*e2[2] - d[2]*e2[1];
    p[1] = d[2]*e2[0] - d[0]*e2[2];
    p[2] = d[0]*e2[1] - d[1]*e2[0];
    det = 128'(p[0])*e1[0] + 128'(p[1])*e1[1] + 128'(p[2])*e1[2];
    if (tri_cfg.one_sided) begin
      if (det < EPS_DET) return o;
    end else if (det > -EPS_DET && det < EPS_DET) begin
      return o;
    end
    q[0] = tv[1]*e1[2] - tv[2]*e1[1];
    q[1] = tv[2]*e1[0] - tv[0]*e1[2];
    q[2] = tv[0]*e1[1] - tv[1]*e1[0];
    un = 128'(p[0])*tv[0] + 128'(p[1])*tv[1] + 128'(p[2])*tv[2];
    vn = 128'(q[0])*d[0] + 128'(q[1])*d[1] + 128'(q[2])*d[2];
    xn = 128'(q[0])*e2[0] + 128'(q[1])*e2[1] + 128'(q[2])*e2[2];
    neg = det < 0;
    if (neg) begin
      det = -det; un = -un; vn = -vn; xn = -xn;
    end
    if (un < 0 || un > det) return o;
    if (vn < 0 || vn > det - un) return o;
    // Floor division: SystemVerilog divides toward zero.
    num = xn <<< 16;
    q128 = num / det;
    if (num < 0 && q128 * det != num) q128 = q128 - 1;
    tq = q128;
    md = longint'(tri_cfg.near_limit);
    if (tq < md) return o;
    if (tq > 128'sd2147483647) tq = 128'sd2147483647;
    if (tq < -128'sd2147483648) tq = -128'sd2147483648;
    nv[0] = e1[1]*e2[2] - e1[2]*e2[1];
    nv[1] = e1[2]*e2[0] - e1[0]*e2[2];
    nv[2] = e1[0]*e2[1] - e1[1]*e2[0];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = iabs(nv[i]);
      if (m[i] > mx) mx = m[i];
    end
    o.hit = 1'b1;
    o.hit_distance = tq[31:0];
    o.hit_material = tri_cfg.material_tag;
    if (mx == 0) return o;
    while (mx >= (64'sd1 <<< 30)) begin
      mx = mx >>> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >>> 1;
    end
    while (mx < (64'sd1 <<< 29)) begin
      mx = mx <<< 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] <<< 1;
    end
    s = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
    l = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      cq = ((m[i] <<< 14) + (l >>> 1)) / l;
      if (cq > 16384) cq = 16384;
      if ((nv[i] < 0) != neg) cq = -cq;
      m[i] = cq;
    end
    o.normal_x = m[0][15:0];
    o.normal_y = m[1][15:0];
    o.normal_z = m[2][15:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // Ray driver.
  always @(posedge clk) begin
    if (!rst) begin
      if (!ray_valid_r || ray_ch.ready) begin
        if (ray_valid_r) expected_res.push_back(intersect_ray(ray_data_r));
        if (pending_rays.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          ray_valid_r <= 1'b1;
          ray_data_r <= pending_rays.pop_front();
        end else begin
          ray_valid_r <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    res_t got, want;
    if (!rst) begin
      if (res_ch.valid && res_ready_r) begin
        got = res_ch.data;
        if (expected_res.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = expected_res.pop_front();
          if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
          if (got.hit_distance !== want.hit_distance)
            report_mismatch("hit_distance", got.hit_distance, want.hit_distance);
          if (got.normal_x !== want.normal_x)
            report_mismatch("normal_x", got.normal_x, want.normal_x);
          if (got.normal_y !== want.normal_y)
            report_mismatch("normal_y", got.normal_y, want.normal_y);
          if (got.normal_z !== want.normal_z)
            report_mismatch("normal_z", got.normal_z, want.normal_z);
          if (got.hit_material !== want.hit_material)
            report_mismatch("hit_material", got.hit_material, want.hit_material);
        end
      end
      res_ready_r <= (hold_off_cycles == 0) && ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted down here.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
  end

  task automatic reg_write(logic [5:0] addr, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic logic [59:0] pack_vertex(int x, int y, int z);
    return {20'(z), 20'(y), 20'(x)};
  endfunction

  task automatic load_triangle(cfg_t c);
    tri_cfg = c;
    reg_write(ADDR_VA, {4'hF, c.vertex_a});
    reg_write(ADDR_VB, {4'hA, c.vertex_b});
    reg_write(ADDR_VC, {4'h5, c.vertex_c});
    reg_write(ADDR_OS, {63'h5A5A, c.one_sided});
    reg_write(ADDR_MD, {32'hDEAD, c.near_limit});
    reg_write(ADDR_MT, {56'h77, c.material_tag});
  endtask

  task automatic wait_drained();
    while (pending_rays.size() > 0 || ray_valid_r || expected_res.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic ray_t random_ray();
    ray_t r;
    r = 120'({$urandom, $urandom, $urandom, $urandom});
    return r;
  endfunction

  // Aim at a random point in the triangle's neighborhood from a random origin.
  function automatic ray_t aimed_ray(int spread);
    ray_t r;
    int ox, oy, oz, tx, ty, tz;
    int w0, w1;
    w0 = $urandom_range(1200, 0) - 100;
    w1 = $urandom_range(1200 - w0 > 0 ? 1200 - w0 : 0, 0) - 100;
    tx = int'(sx20(tri_cfg.vertex_a[19:0]));
    ty = int'(sx20(tri_cfg.vertex_a[39:20]));
    tz = int'(sx20(tri_cfg.vertex_a[59:40]));
    tx += int'(((sx20(tri_cfg.vertex_b[19:0]) - tx) * w0 +
                (sx20(tri_cfg.vertex_c[19:0]) - tx) * w1) / 1000);
    ty += int'(((sx20(tri_cfg.vertex_b[39:20]) - ty) * w0 +
                (sx20(tri_cfg.vertex_c[39:20]) - ty) * w1) / 1000);
    tz += int'(((sx20(tri_cfg.vertex_b[59:40]) - tz) * w0 +
                (sx20(tri_cfg.vertex_c[59:40]) - tz) * w1) / 1000);
    ox = int'($urandom_range(2 * spread, 0)) - spread;
    oy = int'($urandom_range(2 * spread, 0)) - spread;
    oz = int'($urandom_range(2 * spread, 0)) - spread;
    r.origin_x = 20'(ox); r.origin_y = 20'(oy); r.origin_z = 20'(oz);
    r.dir_x = 20'((tx - ox) / 2); r.dir_y = 20'((ty - oy) / 2); r.dir_z = 20'((tz - oz) / 2);
    return r;
  endfunction

  function automatic cfg_t random_triangle(int span);
    cfg_t c;
    c.vertex_a = pack_vertex($urandom_range(2*span,0)-span, $urandom_range(2*span,0)-span,
                             $urandom_range(2*span,0)-span);
    c.vertex_b = pack_vertex($urandom_range(2*span,0)-span, $urandom_range(2*span,0)-span,
                             $urandom_range(2*span,0)-span);
    c.vertex_c = pack_vertex($urandom_range(2*span,0)-span, $urandom_range(2*span,0)-span,
                             $urandom_range(2*span,0)-span);
    c.one_sided = 1'($urandom_range(1, 0));
    c.near_limit = ($urandom_range(3, 0) == 0) ? 32'($urandom) : -32'sd65536;
    c.material_tag = 8'($urandom_range(255, 0));
    return c;
  endfunction

  task automatic run_phase(int n, int idle, int stall, int spread);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9, 0) < 7) pending_rays.push_back(aimed_ray(spread));
      else pending_rays.push_back(random_ray());
    end
    wait_drained();
  endtask

  initial begin
    cfg_t c;
    ray_t r;
    tri_cfg = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!ray_ch.ready) @(posedge clk);

    // Directed: degenerate zero triangle, then a unit triangle in the z = 0 plane.
    r = '0; r.dir_z = 20'sd1024;
    pending_rays.push_back(r);
    wait_drained();
    c = '0;
    c.vertex_a = pack_vertex(0, 0, 0);
    c.vertex_b = pack_vertex(1024, 0, 0);
    c.vertex_c = pack_vertex(0, 1024, 0);
    c.material_tag = 8'hFF;
    c.near_limit = 32'sh80000000;
    load_triangle(c);
    wait_drained();
    // Front hit, back hit, edges, corner, parallel ray, outside.
    r = '0; r.origin_x = 20'sd256; r.origin_y = 20'sd256; r.origin_z = 20'sd1024;
    r.dir_z = -20'sd1024;
    pending_rays.push_back(r);
    r.origin_z = -20'sd1024; r.dir_z = 20'sd1024; pending_rays.push_back(r);
    r.origin_x = 20'sd0; r.origin_y = 20'sd0; pending_rays.push_back(r);
    r.origin_x = 20'sd512; r.origin_y = 20'sd512; pending_rays.push_back(r);
    r.origin_x = 20'sd513; pending_rays.push_back(r);
    r.origin_x = -20'sd1; r.origin_y = 20'sd0; pending_rays.push_back(r);
    r.dir_x = 20'sd1024; r.dir_z = 20'sd0; pending_rays.push_back(r);
    r = '0; r.origin_z = 20'sh7FFFF; r.origin_x = 20'sd1; r.origin_y = 20'sd1;
    r.dir_z = -20'sd1;
    pending_rays.push_back(r);
    r.origin_z = 20'sh80000; r.dir_z = 20'sd1; pending_rays.push_back(r);
    r = '1; pending_rays.push_back(r);
    r = {6{20'h80000}}; pending_rays.push_back(r);
    r = {6{20'h7FFFF}}; pending_rays.push_back(r);
    r = '0; r.origin_x = 20'sd100; r.origin_y = 20'sd100; r.origin_z = 20'sd1024;
    r.dir_z = 20'sh80000;
    pending_rays.push_back(r);
    wait_drained();
    c.one_sided = 1'b1; c.near_limit = 32'sh7FFFFFFF; c.material_tag = 8'h00;
    load_triangle(c);
    r = '0; r.origin_x = 20'sd256; r.origin_y = 20'sd256; r.origin_z = 20'sd1024;
    r.dir_z = -20'sd1024;
    pending_rays.push_back(r);
    r.origin_z = -20'sd1024; r.dir_z = 20'sd1024; pending_rays.push_back(r);
    wait_drained();
    c.near_limit = 32'sd65536;
    load_triangle(c);
    r.origin_z = -20'sd1024; r.dir_z = 20'sd1024; pending_rays.push_back(r);
    r.dir_z = 20'sd1023; pending_rays.push_back(r);
    wait_drained();
    // Extreme vertices.
    c.vertex_a = pack_vertex(-524288, -524288, -524288);
    c.vertex_b = pack_vertex(524287, -524288, 524287);
    c.vertex_c = pack_vertex(-524288, 524287, 524287);
    c.one_sided = 1'b0; c.near_limit = 32'sh80000000;
    load_triangle(c);
    run_phase(8, 0, 0, 524287);

    // Random phases; each new triangle is loaded only while idle.
    for (int ph = 0; ph < 12; ph++) begin
      load_triangle(random_triangle(ph % 3 == 0 ? 524287 : (ph % 3 == 1 ? 20000 : 2000)));
      case (ph % 4)
        0: run_phase(104, 0, 0, 30000);
        1: run_phase(104, 72, 0, 30000);
        2: run_phase(104, 0, 72, 524287);
        default: run_phase(104, 33, 33, 30000);
      endcase
    end

    // Receiver holds off long enough for the block to fill and stall rays.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 300;
    for (int i = 0; i < 80; i++) pending_rays.push_back(aimed_ray(20000));
    wait_drained();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
